### rtl/bm3_pkg.sv
package bm3_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int PIX_W  = 8;
    localparam int SIZE_W = 9;

    // column index, clamped width, row position (may run one past the frame in drain)
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_ERODE  = 3'd0;
    localparam logic [2:0] REG_EIGHT  = 3'd1;
    localparam logic [2:0] REG_BLACK  = 3'd2;
    localparam logic [2:0] REG_WHITE  = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel_in;
    } t_bm_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } t_bm_out;

endpackage

### rtl/binary_morphology_3x3_unit.sv
// 3x3 binary dilation / erosion over a raster pixel stream, one item per clock while the output is not stalled.
// the result for a pixel is caused by the item one line plus one pixel later; it is registered
// in stage 1 and then in the output register, and both registers hold under output back-pressure.
// one line memory holds both stored lines and is read, updated and written back once per item.
// reset clears position counters, window, pipeline valids and configuration registers to their defaults;
// the line memory is not cleared and needs no clearing pass.
module binary_morphology_3x3_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bm3_pkg::t_bm_in                     i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bm3_pkg::t_bm_out                    o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bm3_pkg::ADDR_W-1:0]          paddr,
    input  logic [bm3_pkg::DATA_W-1:0]          pwdata,
    output logic [bm3_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);
    import bm3_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] pix;
        logic             have;
        logic             left_ok;
        logic             right_ok;
        logic             top_ok;
        logic             bot_ok;
        logic             last;
    } t_bm3_s1;

    // configuration
    logic              r_erode;
    logic              r_eight;
    logic [PIX_W-1:0]  r_black;
    logic [PIX_W-1:0]  r_white;
    logic [SIZE_W-1:0] r_line_width;
    logic [SIZE_W-1:0] r_frame_height;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erode        <= 1'b0;
            r_eight        <= 1'b1;
            r_black        <= '0;
            r_white        <= '1;
            r_line_width   <= SIZE_W'(256);
            r_frame_height <= SIZE_W'(256);
        end else if (cfg_wr) begin
            unique case (paddr[ADDR_W-1:2])
                REG_ERODE:  r_erode        <= pwdata[0];
                REG_EIGHT:  r_eight        <= pwdata[0];
                REG_BLACK:  r_black        <= pwdata[PIX_W-1:0];
                REG_WHITE:  r_white        <= pwdata[PIX_W-1:0];
                REG_WIDTH:  r_line_width   <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: r_frame_height <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_ERODE:  prdata = DATA_W'(r_erode);
            REG_EIGHT:  prdata = DATA_W'(r_eight);
            REG_BLACK:  prdata = DATA_W'(r_black);
            REG_WHITE:  prdata = DATA_W'(r_white);
            REG_WIDTH:  prdata = DATA_W'(r_line_width);
            REG_HEIGHT: prdata = DATA_W'(r_frame_height);
            default:    prdata = '0;
        endcase
    end

    // clamped frame size
    logic [WD_W-1:0]  w;
    logic [ROW_W-1:0] h;

    always_comb begin
        if (r_line_width == '0) begin
            w = WD_W'(1);
        end else if (32'(r_line_width) > MAX_WIDTH) begin
            w = WD_W'(MAX_WIDTH);
        end else begin
            w = WD_W'(r_line_width);
        end
        if (r_frame_height == '0) begin
            h = ROW_W'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h = ROW_W'(MAX_HEIGHT);
        end else begin
            h = ROW_W'(r_frame_height);
        end
    end

    // input position and per-item control
    logic [COL_W-1:0] r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic [COL_W-1:0] n_in_col;
    logic [ROW_W-1:0] n_in_row;
    logic [COL_W-1:0] ic;
    logic [ROW_W-1:0] ir;
    logic [COL_W-1:0] cc;
    logic [ROW_W-1:0] cr;
    logic             have_pos;
    logic             restart;
    logic             drop;
    logic             take;
    t_bm3_s1          s0;

    t_bm3_s1          r_s1;
    logic             r_s1_valid;
    logic             s1_adv;
    logic             r_out_valid;

    always_comb begin
        restart = !i_in_data.op && (r_in_row >= h);
        // flush before the frame is complete, or when idle
        drop    = i_in_data.op && (r_in_row < h);
        ir      = restart ? '0 : r_in_row;
        ic      = restart ? '0 : r_in_col;

        if (ic != '0) begin
            have_pos = ir != '0;
            cr       = ir - ROW_W'(1);
            cc       = ic - COL_W'(1);
        end else begin
            have_pos = ir >= ROW_W'(2);
            cr       = ir - ROW_W'(2);
            cc       = COL_W'(w - WD_W'(1));
        end

        s0.addr     = ic;
        s0.pix      = i_in_data.op ? '0 : i_in_data.pixel_in;
        s0.have     = have_pos && (cr < h) && (WD_W'(cc) < w);
        s0.left_ok  = cc != '0;
        s0.right_ok = (WD_W'(cc) + WD_W'(1)) < w;
        s0.top_ok   = cr != '0;
        s0.bot_ok   = (cr + ROW_W'(1)) < h;
        s0.last     = ((cr + ROW_W'(1)) == h) && ((WD_W'(cc) + WD_W'(1)) == w);

        if ((WD_W'(ic) + WD_W'(1)) >= w) begin
            n_in_col = '0;
            n_in_row = ir + ROW_W'(1);
        end else begin
            n_in_col = ic + COL_W'(1);
            n_in_row = ir;
        end
        // drain finished: back to the top of the frame
        if (i_in_data.op && (ic == '0) && (ir >= h + ROW_W'(1))) begin
            n_in_col = '0;
            n_in_row = '0;
        end
    end

    assign s1_adv     = r_s1_valid && (!r_s1.have || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign take       = i_in_valid && o_in_ready && !drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
        end else if (take) begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
        end
    end

    // line memory: upper line in the high byte, middle line in the low byte
    logic [2*PIX_W-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic               r_fwd_hit;
    logic [2*PIX_W-1:0] rd_word;
    logic [2*PIX_W-1:0] wr_data;
    logic [PIX_W-1:0]   top_pix;
    logic [PIX_W-1:0]   mid_pix;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_line_mem[r_s1.addr] <= wr_data;
        end
        if (take) begin
            r_rd_data  <= r_line_mem[ic];
            r_fwd_data <= wr_data;
        end
    end

    // the read misses a write to the same entry at the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (take) begin
            r_fwd_hit <= s1_adv && (r_s1.addr == ic);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= take || (r_s1_valid && !s1_adv);
        end
        if (take) begin
            r_s1 <= s0;
        end
    end

    // window update and neighborhood test
    logic [PIX_W-1:0] r_win [9];
    logic [PIX_W-1:0] n_win [9];
    logic [PIX_W-1:0] target;
    logic [PIX_W-1:0] res;

    always_comb begin
        logic use_it;
        rd_word = r_fwd_hit ? r_fwd_data : r_rd_data;
        top_pix = rd_word[2*PIX_W-1:PIX_W];
        mid_pix = rd_word[PIX_W-1:0];
        wr_data = {mid_pix, r_s1.pix};

        for (int i = 0; i < 6; i++) begin
            n_win[i] = r_win[i+3];
        end
        n_win[6] = top_pix;
        n_win[7] = mid_pix;
        n_win[8] = r_s1.pix;

        target = r_erode ? r_white : r_black;
        res    = n_win[4];
        for (int k = 0; k < 3; k++) begin
            for (int r = 0; r < 3; r++) begin
                use_it = ((k != 1) || (r != 1))
                    && (r_eight || (k == 1) || (r == 1))
                    && ((k != 0) || r_s1.left_ok)
                    && ((k != 2) || r_s1.right_ok)
                    && ((r != 0) || r_s1.top_ok)
                    && ((r != 2) || r_s1.bot_ok);
                if (use_it && (n_win[k*3+r] == target)) begin
                    res = target;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    // output register
    t_bm_out r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1.have) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_adv && r_s1.have) begin
            r_out_data.pixel_out <= res;
            r_out_data.frame_end <= r_s1.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/bm3_checker.sv
module bm3_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input bm3_pkg::t_bm_out           o_out_data,
    input logic [bm3_pkg::ADDR_W-1:0] paddr,
    input logic [bm3_pkg::DATA_W-1:0] prdata,
    input logic                       pready
);
    import bm3_pkg::*;

    // a result never shows in the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // one-bit registers read back without stray upper bits
    a_reg_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (paddr[ADDR_W-1:2] == REG_ERODE) || (paddr[ADDR_W-1:2] == REG_EIGHT)
        |-> (prdata[DATA_W-1:1] == '0))
        else $error("flag register reads wider than one bit");

endmodule

bind binary_morphology_3x3_unit bm3_checker u_bm3_checker (.*);
